// ===== hw/rtl/shpd_pkg.sv =====
package shpd_pkg;

  localparam int unsigned PAYLOAD_MAX_DEF = 32;
  localparam int unsigned SYNC_NEEDED     = 2;
  localparam int unsigned HDR_COUNT       = 5;
  localparam int unsigned HDR_DEST_POS    = 1;
  localparam int unsigned HDR_LEN_POS     = 4;

  localparam logic [7:0] SYNC_BYTE      = 8'hAA;
  localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

  typedef struct packed {
    logic [7:0] packet_id;
    logic [7:0] dest_addr;
    logic [7:0] source_addr;
    logic [7:0] transmitter_addr;
    logic [7:0] payload_length;
    logic [7:0] check_byte;
  } shpd_desc_t;

  typedef struct packed {
    logic [7:0] packet_id;
    logic [7:0] dest_addr;
    logic [7:0] source_addr;
    logic [7:0] transmitter_addr;
    logic [7:0] payload_length;
    logic [7:0] check_byte;
    logic [7:0] data_byte;
    logic [4:0] data_index;
    logic       data_valid;
    logic       truncated;
    logic       last;
  } shpd_result_t;

  function automatic int unsigned ram_aw(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== hw/rtl/shpd_stream_if.sv =====
interface shpd_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sync_header_packet_deframer.sv =====
// Sync-header packet deframer.
// rx_i: one received link byte per transfer. Two 0xAA bytes open a frame,
//   followed by five header bytes (id, dest, source, transmitter, length),
//   length payload bytes and a checksum byte.
// cfg_i: writes the device id; always ready, write only while idle.
// pkt_o: one result per stored payload byte (or one result for an empty
//   payload) for frames addressed to the device id or to broadcast 0xFF.
// Sync and header bytes are always taken. The front end hands a finished
//   frame to a one-entry descriptor register; the back end reads the payload
//   memory with a registered read: the first result passes the descriptor
//   register, memory read and output register (no read for an empty payload),
//   each further one the memory read, then output register, so pkt_o.valid
//   drops between results of a run. Stored payload bytes of the next frame
//   stall rx_i until the current run has drained, since both share the single
//   payload memory. A matching frame's checksum byte waits on a full descriptor.
// A stall on pkt_o holds the output register and backs up into the
//   descriptor register; header bytes of the next frame are still taken.
// Reset sends the front end to sync hunting and the back end to idle, and
//   clears the device id to 0. The payload memory needs no clearing pass.
module sync_header_packet_deframer #(
  parameter int unsigned PAYLOAD_MAX = shpd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  shpd_stream_if.sink   rx_i,
  shpd_stream_if.sink   cfg_i,
  shpd_stream_if.source pkt_o
);
  import shpd_pkg::*;

  localparam int unsigned AW = ram_aw(PAYLOAD_MAX);

  logic            desc_valid, desc_ready, back_busy;
  shpd_desc_t      desc;
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [7:0]      wr_data, rd_data;

  shpd_front #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .cfg_i        (cfg_i),
    .back_busy_i  (back_busy),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .desc_ready_i (desc_ready),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  shpd_ram #(.WIDTH(8), .DEPTH(PAYLOAD_MAX)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  shpd_back #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .desc_ready_o (desc_ready),
    .busy_o       (back_busy),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .pkt_o        (pkt_o)
  );
endmodule

// ===== hw/rtl/shpd_ram.sv =====
module shpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [shpd_pkg::ram_aw(DEPTH)-1:0]     wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [shpd_pkg::ram_aw(DEPTH)-1:0]     rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end
endmodule

// ===== hw/rtl/shpd_front.sv =====
module shpd_front #(
  parameter int unsigned PAYLOAD_MAX = shpd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  shpd_stream_if.sink                              rx_i,
  shpd_stream_if.sink                              cfg_i,
  input  logic                                     back_busy_i,
  output logic                                     desc_valid_o,
  output shpd_pkg::shpd_desc_t                     desc_o,
  input  logic                                     desc_ready_i,
  output logic                                     wr_en_o,
  output logic [shpd_pkg::ram_aw(PAYLOAD_MAX)-1:0] wr_addr_o,
  output logic [7:0]                               wr_data_o
);
  import shpd_pkg::*;

  localparam int unsigned AW   = ram_aw(PAYLOAD_MAX);
  localparam logic [7:0]  PMAX = 8'(PAYLOAD_MAX);

  logic [1:0]  sync_q;
  logic [2:0]  hdr_pos_q;
  logic [7:0]  hdr_q [HDR_COUNT];
  logic [7:0]  pay_cnt_q;
  logic [7:0]  dev_id_q;
  logic        desc_valid_q;
  shpd_desc_t  desc_q;

  logic in_sync, in_hdr, in_pay, store, dest_match, xfer, busy;

  assign busy       = back_busy_i || desc_valid_q;
  assign in_sync    = sync_q < 2'(SYNC_NEEDED);
  assign in_hdr     = hdr_pos_q < 3'(HDR_COUNT);
  assign in_pay     = pay_cnt_q < hdr_q[HDR_LEN_POS];
  assign store      = pay_cnt_q < PMAX;
  assign dest_match = (hdr_q[HDR_DEST_POS] == BROADCAST_ADDR) ||
                      (hdr_q[HDR_DEST_POS] == dev_id_q);

  always_comb begin
    if (in_sync || in_hdr) begin
      rx_i.ready = 1'b1;
    end else if (in_pay) begin
      rx_i.ready = !(store && busy);
    end else begin
      rx_i.ready = !(dest_match && desc_valid_q);
    end
  end

  assign xfer        = rx_i.valid && rx_i.ready;
  assign cfg_i.ready = 1'b1;

  assign wr_en_o      = xfer && !in_sync && !in_hdr && in_pay && store;
  assign wr_addr_o    = pay_cnt_q[AW-1:0];
  assign wr_data_o    = rx_i.data;
  assign desc_valid_o = desc_valid_q;
  assign desc_o       = desc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q       <= '0;
      hdr_pos_q    <= '0;
      pay_cnt_q    <= '0;
      dev_id_q     <= '0;
      desc_valid_q <= 1'b0;
      desc_q       <= '0;
      for (int i = 0; i < HDR_COUNT; i++) begin
        hdr_q[i] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        dev_id_q <= cfg_i.data;
      end
      if (desc_valid_q && desc_ready_i) begin
        desc_valid_q <= 1'b0;
      end
      if (xfer) begin
        if (in_sync) begin
          if (rx_i.data == SYNC_BYTE) begin
            sync_q <= sync_q + 2'd1;
          end
        end else if (in_hdr) begin
          hdr_q[hdr_pos_q] <= rx_i.data;
          hdr_pos_q        <= hdr_pos_q + 3'd1;
        end else if (in_pay) begin
          pay_cnt_q <= pay_cnt_q + 8'd1;
        end else begin
          // checksum: close the frame, hand matching packets to the back end
          sync_q    <= '0;
          hdr_pos_q <= '0;
          pay_cnt_q <= '0;
          if (dest_match) begin
            desc_valid_q            <= 1'b1;
            desc_q.packet_id        <= hdr_q[0];
            desc_q.dest_addr        <= hdr_q[1];
            desc_q.source_addr      <= hdr_q[2];
            desc_q.transmitter_addr <= hdr_q[3];
            desc_q.payload_length   <= hdr_q[HDR_LEN_POS];
            desc_q.check_byte       <= rx_i.data;
          end
        end
      end
    end
  end
endmodule

// ===== hw/rtl/shpd_back.sv =====
module shpd_back #(
  parameter int unsigned PAYLOAD_MAX = shpd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     desc_valid_i,
  input  shpd_pkg::shpd_desc_t                     desc_i,
  output logic                                     desc_ready_o,
  output logic                                     busy_o,
  output logic                                     rd_en_o,
  output logic [shpd_pkg::ram_aw(PAYLOAD_MAX)-1:0] rd_addr_o,
  input  logic [7:0]                               rd_data_i,
  shpd_stream_if.source                            pkt_o
);
  import shpd_pkg::*;

  localparam int unsigned AW   = ram_aw(PAYLOAD_MAX);
  localparam logic [7:0]  PMAX = 8'(PAYLOAD_MAX);

  typedef enum logic [1:0] {
    IDLE,
    FETCH,
    SEND
  } state_e;

  state_e       state_q;
  shpd_desc_t   cur_q;
  logic [7:0]   idx_q;
  shpd_result_t res_q;

  logic [7:0] idx_nxt, new_stored, cur_stored;
  logic       new_trunc, cur_trunc;

  assign new_trunc  = desc_i.payload_length > PMAX;
  assign new_stored = new_trunc ? PMAX : desc_i.payload_length;
  assign cur_trunc  = cur_q.payload_length > PMAX;
  assign cur_stored = cur_trunc ? PMAX : cur_q.payload_length;
  assign idx_nxt    = idx_q + 8'd1;

  assign desc_ready_o = (state_q == IDLE);
  assign busy_o       = (state_q != IDLE);
  assign pkt_o.valid  = (state_q == SEND);
  assign pkt_o.data   = res_q;

  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    case (state_q)
      IDLE: begin
        rd_en_o = desc_valid_i && (new_stored != 8'd0);
      end
      SEND: begin
        rd_en_o   = pkt_o.ready && !res_q.last;
        rd_addr_o = idx_nxt[AW-1:0];
      end
      default: begin
        rd_en_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      cur_q   <= '0;
      idx_q   <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (desc_valid_i) begin
            cur_q <= desc_i;
            idx_q <= '0;
            if (new_stored == 8'd0) begin
              res_q.packet_id        <= desc_i.packet_id;
              res_q.dest_addr        <= desc_i.dest_addr;
              res_q.source_addr      <= desc_i.source_addr;
              res_q.transmitter_addr <= desc_i.transmitter_addr;
              res_q.payload_length   <= desc_i.payload_length;
              res_q.check_byte       <= desc_i.check_byte;
              res_q.data_byte        <= '0;
              res_q.data_index       <= '0;
              res_q.data_valid       <= 1'b0;
              res_q.truncated        <= new_trunc;
              res_q.last             <= 1'b1;
              state_q                <= SEND;
            end else begin
              state_q <= FETCH;
            end
          end
        end
        FETCH: begin
          res_q.packet_id        <= cur_q.packet_id;
          res_q.dest_addr        <= cur_q.dest_addr;
          res_q.source_addr      <= cur_q.source_addr;
          res_q.transmitter_addr <= cur_q.transmitter_addr;
          res_q.payload_length   <= cur_q.payload_length;
          res_q.check_byte       <= cur_q.check_byte;
          res_q.data_byte        <= rd_data_i;
          res_q.data_index       <= idx_q[4:0];
          res_q.data_valid       <= 1'b1;
          res_q.truncated        <= cur_trunc;
          res_q.last             <= (idx_nxt == cur_stored);
          state_q                <= SEND;
        end
        SEND: begin
          if (pkt_o.ready) begin
            if (res_q.last) begin
              state_q <= IDLE;
            end else begin
              idx_q   <= idx_nxt;
              state_q <= FETCH;
            end
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end
endmodule

// ===== hw/rtl/shpd_checker.sv =====
module shpd_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   pkt_valid_i,
  input logic                   pkt_ready_i,
  input shpd_pkg::shpd_result_t pkt_data_i
);
  import shpd_pkg::*;

  logic pkt_xfer;
  assign pkt_xfer = pkt_valid_i && pkt_ready_i;

  a_pkt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_i && !pkt_ready_i |=> pkt_valid_i && $stable(pkt_data_i))
    else $error("stalled result changed");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_i && !pkt_data_i.data_valid |->
      pkt_data_i.last && (pkt_data_i.data_byte == 8'd0) &&
      (pkt_data_i.data_index == 5'd0) && (pkt_data_i.payload_length == 8'd0))
    else $error("malformed empty-packet result");

  a_run_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_xfer && !pkt_data_i.last |=> !pkt_valid_i)
    else $error("result inside a run without memory fetch cycle");

  a_run_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_xfer && !pkt_data_i.last ##2 pkt_valid_i |->
      pkt_data_i.packet_id == $past(pkt_data_i.packet_id, 2) &&
      pkt_data_i.check_byte == $past(pkt_data_i.check_byte, 2) &&
      pkt_data_i.data_index == $past(pkt_data_i.data_index, 2) + 5'd1)
    else $error("header or index broke within a run");
endmodule

bind sync_header_packet_deframer shpd_checker u_shpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pkt_valid_i (pkt_o.valid),
  .pkt_ready_i (pkt_o.ready),
  .pkt_data_i  (pkt_o.data)
);
